[hw/rtl/lbe_pkg.sv]
// Shared types, codes and fixed-point helpers of the Lagrange basis evaluator.
// Depends on nothing; every other file of the block but lbe_div refers to it by scoped names.
package lbe_pkg;

	localparam int MAX_LINE_ORDER_DEF = 7;
	localparam int FRAC_BITS_DEF      = 16;
	localparam int QUEUE_DEPTH        = 2;

	// register index of basis_order on the configuration port
	localparam logic REG_BASIS_ORDER = 1'b0;

	typedef enum logic [1:0] {
		CELL_POINT = 2'd0,
		CELL_LINE  = 2'd1,
		CELL_TRI   = 2'd2,
		CELL_TET   = 2'd3
	} cell_t;

	// operand base of a linear factor
	typedef enum logic [2:0] {
		BASE_ONE = 3'd0,
		BASE_X   = 3'd1,
		BASE_Y   = 3'd2,
		BASE_Z   = 3'd3,
		BASE_W   = 3'd4,
		BASE_U   = 3'd5
	} base_t;

	// scaling applied to the base: 1, 2, 4, 9/2, 27/2, 27
	typedef enum logic [2:0] {
		SCL_1   = 3'd0,
		SCL_2   = 3'd1,
		SCL_4   = 3'd2,
		SCL_9H  = 3'd3,
		SCL_27H = 3'd4,
		SCL_27  = 3'd5
	} scl_t;

	// constant subtracted from the value part
	typedef enum logic [1:0] {
		CST_0     = 2'd0,
		CST_HALF  = 2'd1,
		CST_THIRD = 2'd2,
		CST_TWO3  = 2'd3
	} cst_t;

	// value and one partial derivative (the selected axis)
	typedef struct packed {
		logic [31:0] v;
		logic [31:0] g;
	} dual_t;

	// one classified request as it waits in the queue
	typedef struct packed {
		cell_t       cell_kind;
		logic        out_grad;
		dual_t       x;
		dual_t       y;
		dual_t       z;
		dual_t       w;
		dual_t       u;
	} item_t;

	typedef struct packed {
		base_t base;
		scl_t  scl;
		cst_t  cst;
	} lin_t;

	// basis program: first factor times nterm more factors
	typedef struct packed {
		logic [1:0] nterm;
		lin_t       l0;
		lin_t       l1;
		lin_t       l2;
	} prog_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
		if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (a < -64'sd2147483648) return 32'sh80000000;
		return a[31:0];
	endfunction

	// divide by 2^s, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p, input int s);
		logic [63:0] m;
		logic [63:0] r;
		if (s == 0) return p;
		m = p[63] ? 64'(-p) : 64'(p);
		r = (m + (64'd1 << (s - 1))) >> s;
		return p[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic dual_t dsub(input dual_t a, input dual_t b);
		dual_t r;
		r.v = sat32(64'($signed(a.v)) - 64'($signed(b.v)));
		r.g = sat32(64'($signed(a.g)) - 64'($signed(b.g)));
		return r;
	endfunction

	function automatic dual_t dtwice(input dual_t a);
		dual_t r;
		r.v = sat32(64'($signed(a.v)) <<< 1);
		r.g = sat32(64'($signed(a.g)) <<< 1);
		return r;
	endfunction

	function automatic lin_t mk(input base_t b, input scl_t s, input cst_t c);
		lin_t l;
		l.base = b;
		l.scl  = s;
		l.cst  = c;
		return l;
	endfunction

	function automatic prog_t p1(input lin_t a);
		prog_t p;
		p.nterm = 2'd0;
		p.l0 = a;
		p.l1 = a;
		p.l2 = a;
		return p;
	endfunction

	function automatic prog_t p2(input lin_t a, input lin_t b);
		prog_t p;
		p.nterm = 2'd1;
		p.l0 = a;
		p.l1 = b;
		p.l2 = b;
		return p;
	endfunction

	function automatic prog_t p3(input lin_t a, input lin_t b, input lin_t c);
		prog_t p;
		p.nterm = 2'd2;
		p.l0 = a;
		p.l1 = b;
		p.l2 = c;
		return p;
	endfunction

	// factor program of basis idx for simplex cells (points and orders zero give 1.0)
	function automatic prog_t prog_of(input cell_t ck, input logic [2:0] n,
			input logic [3:0] idx);
		prog_t p;
		lin_t  one_l;
		one_l = mk(BASE_ONE, SCL_1, CST_0);
		p = p1(one_l);
		if (ck == CELL_TRI && n == 3'd1) begin
			unique case (idx)
				4'd0:    p = p1(mk(BASE_W, SCL_1, CST_0));
				4'd1:    p = p1(mk(BASE_X, SCL_1, CST_0));
				default: p = p1(mk(BASE_Y, SCL_1, CST_0));
			endcase
		end else if (ck == CELL_TET && n == 3'd1) begin
			unique case (idx)
				4'd0:    p = p1(mk(BASE_W, SCL_1, CST_0));
				4'd1:    p = p1(mk(BASE_X, SCL_1, CST_0));
				4'd2:    p = p1(mk(BASE_Y, SCL_1, CST_0));
				default: p = p1(mk(BASE_Z, SCL_1, CST_0));
			endcase
		end else if (ck == CELL_TRI && n == 3'd2) begin
			unique case (idx)
				4'd0: p = p2(mk(BASE_W, SCL_1, CST_0), mk(BASE_U, SCL_1, CST_0));
				4'd1: p = p2(mk(BASE_X, SCL_2, CST_0), mk(BASE_X, SCL_1, CST_HALF));
				4'd2: p = p2(mk(BASE_Y, SCL_2, CST_0), mk(BASE_Y, SCL_1, CST_HALF));
				4'd3: p = p2(mk(BASE_X, SCL_4, CST_0), mk(BASE_W, SCL_1, CST_0));
				4'd4: p = p2(mk(BASE_X, SCL_4, CST_0), mk(BASE_Y, SCL_1, CST_0));
				default: p = p2(mk(BASE_Y, SCL_4, CST_0), mk(BASE_W, SCL_1, CST_0));
			endcase
		end else if (ck == CELL_TET && n == 3'd2) begin
			unique case (idx)
				4'd0: p = p2(mk(BASE_W, SCL_1, CST_0), mk(BASE_U, SCL_1, CST_0));
				4'd1: p = p2(mk(BASE_X, SCL_2, CST_0), mk(BASE_X, SCL_1, CST_HALF));
				4'd2: p = p2(mk(BASE_Y, SCL_2, CST_0), mk(BASE_Y, SCL_1, CST_HALF));
				4'd3: p = p2(mk(BASE_Z, SCL_2, CST_0), mk(BASE_Z, SCL_1, CST_HALF));
				4'd4: p = p2(mk(BASE_X, SCL_4, CST_0), mk(BASE_W, SCL_1, CST_0));
				4'd5: p = p2(mk(BASE_X, SCL_4, CST_0), mk(BASE_Y, SCL_1, CST_0));
				4'd6: p = p2(mk(BASE_Y, SCL_4, CST_0), mk(BASE_W, SCL_1, CST_0));
				4'd7: p = p2(mk(BASE_Z, SCL_4, CST_0), mk(BASE_W, SCL_1, CST_0));
				4'd8: p = p2(mk(BASE_X, SCL_4, CST_0), mk(BASE_Z, SCL_1, CST_0));
				default: p = p2(mk(BASE_Y, SCL_4, CST_0), mk(BASE_Z, SCL_1, CST_0));
			endcase
		end else if (ck == CELL_TRI && n == 3'd3) begin
			unique case (idx)
				4'd0: p = p3(mk(BASE_W, SCL_9H, CST_0), mk(BASE_W, SCL_1, CST_TWO3),
						mk(BASE_W, SCL_1, CST_THIRD));
				4'd1: p = p3(mk(BASE_X, SCL_9H, CST_0), mk(BASE_X, SCL_1, CST_TWO3),
						mk(BASE_X, SCL_1, CST_THIRD));
				4'd2: p = p3(mk(BASE_Y, SCL_9H, CST_0), mk(BASE_Y, SCL_1, CST_TWO3),
						mk(BASE_Y, SCL_1, CST_THIRD));
				4'd3: p = p3(mk(BASE_W, SCL_27H, CST_0), mk(BASE_X, SCL_1, CST_0),
						mk(BASE_W, SCL_1, CST_THIRD));
				4'd4: p = p3(mk(BASE_W, SCL_27H, CST_0), mk(BASE_X, SCL_1, CST_0),
						mk(BASE_X, SCL_1, CST_THIRD));
				4'd5: p = p3(mk(BASE_X, SCL_27H, CST_0), mk(BASE_Y, SCL_1, CST_0),
						mk(BASE_X, SCL_1, CST_THIRD));
				4'd6: p = p3(mk(BASE_X, SCL_27H, CST_0), mk(BASE_Y, SCL_1, CST_0),
						mk(BASE_Y, SCL_1, CST_THIRD));
				4'd7: p = p3(mk(BASE_Y, SCL_27H, CST_0), mk(BASE_W, SCL_1, CST_0),
						mk(BASE_Y, SCL_1, CST_THIRD));
				4'd8: p = p3(mk(BASE_Y, SCL_27H, CST_0), mk(BASE_W, SCL_1, CST_0),
						mk(BASE_W, SCL_1, CST_THIRD));
				default: p = p3(mk(BASE_W, SCL_27, CST_0), mk(BASE_X, SCL_1, CST_0),
						mk(BASE_Y, SCL_1, CST_0));
			endcase
		end
		return p;
	endfunction

endpackage

[hw/rtl/lbe_fifo.sv]
// Short request queue between the front and back ends of the basis evaluator.
// Depends on lbe_pkg for the item type.
module lbe_fifo #(
	parameter int DEPTH = lbe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lbe_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output lbe_pkg::item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lbe_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && valid);
		end
	end

endmodule

[hw/rtl/lbe_front.sv]
// Front end: takes a request, converts the coordinates and builds the linear
// operands x, y, z, w and u for the selected axis. Depends on lbe_pkg.
module lbe_front #(
	parameter int FRAC_BITS = lbe_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cell_type,
	input  logic signed [17:0] coord_x,
	input  logic signed [17:0] coord_y,
	input  logic signed [17:0] coord_z,
	input  logic [1:0]         deriv_sel,
	output logic               push,
	output lbe_pkg::item_t     push_item,
	input  logic               full
);

	localparam longint OneL = longint'(1) <<< FRAC_BITS;

	logic               vld_s1;
	logic [1:0]         cell_s1;
	logic signed [17:0] cx_s1;
	logic signed [17:0] cy_s1;
	logic signed [17:0] cz_s1;
	logic [1:0]         sel_s1;
	logic               accept;
	logic [1:0]         axis;
	lbe_pkg::dual_t     one_d;
	lbe_pkg::dual_t     xd;
	lbe_pkg::dual_t     yd;
	lbe_pkg::dual_t     zd;
	lbe_pkg::dual_t     wt;
	lbe_pkg::dual_t     ut;

	// Q1.16 to the internal fraction width, rounded and saturated
	function automatic logic signed [31:0] coord_cvt(input logic signed [17:0] c);
		logic signed [63:0] e;
		e = 64'(c);
		if (FRAC_BITS >= 16) return lbe_pkg::sat32(e <<< (FRAC_BITS - 16));
		return lbe_pkg::sat32(lbe_pkg::rnd_shift(e, 16 - FRAC_BITS));
	endfunction

	assign accept = start && !busy;
	assign busy   = vld_s1 && full;
	assign push   = vld_s1 && !full;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_type;
			cx_s1   <= coord_x;
			cy_s1   <= coord_y;
			cz_s1   <= coord_z;
			sel_s1  <= deriv_sel;
		end
	end

	// classify and build operands
	always_comb begin
		axis    = (lbe_pkg::cell_t'(cell_s1) == lbe_pkg::CELL_LINE) ? 2'd1 : sel_s1;
		one_d.v = 32'(OneL);
		one_d.g = '0;
		xd.v    = coord_cvt(cx_s1);
		xd.g    = (axis == 2'd1) ? 32'(OneL) : '0;
		yd.v    = coord_cvt(cy_s1);
		yd.g    = (axis == 2'd2) ? 32'(OneL) : '0;
		zd.v    = coord_cvt(cz_s1);
		zd.g    = (axis == 2'd3) ? 32'(OneL) : '0;
		wt      = lbe_pkg::dsub(lbe_pkg::dsub(one_d, xd), yd);
		ut      = lbe_pkg::dsub(lbe_pkg::dsub(one_d, lbe_pkg::dtwice(xd)),
				lbe_pkg::dtwice(yd));
		if (lbe_pkg::cell_t'(cell_s1) == lbe_pkg::CELL_TET) begin
			wt = lbe_pkg::dsub(wt, zd);
			ut = lbe_pkg::dsub(ut, lbe_pkg::dtwice(zd));
		end
		push_item.cell_kind = lbe_pkg::cell_t'(cell_s1);
		push_item.out_grad  = (lbe_pkg::cell_t'(cell_s1) != lbe_pkg::CELL_POINT)
				&& (sel_s1 != 2'd0);
		push_item.x = xd;
		push_item.y = yd;
		push_item.z = zd;
		push_item.w = wt;
		push_item.u = ut;
	end

endmodule

[hw/rtl/lbe_div.sv]
// Rounded division of a wide signed numerator by a small nonzero signed
// denominator, eight quotient bits per cycle, saturated to 32 bits. Standalone.
module lbe_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [39:0] num,
	input  logic signed [4:0]  den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int NB     = 40;
	localparam int STEPS  = 8;
	localparam int ROUNDS = NB / STEPS;
	localparam int RCW    = $clog2(ROUNDS);

	logic [NB-1:0]  sh_q;
	logic [3:0]     rem_q;
	logic [3:0]     d_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic [RCW-1:0] cnt_q;
	logic [NB-1:0]  sh_nx;
	logic [3:0]     rem_nx;
	logic [4:0]     trial;
	logic [NB-1:0]  mag;
	logic [3:0]     dmag;

	assign done = done_q;

	// start operands: 2|num| + |den| over 2|den| gives round-half-away
	always_comb begin
		mag  = num[39] ? NB'(-num) : NB'(num);
		dmag = den[4] ? 4'(-den) : 4'(den);
	end

	// eight restoring steps
	always_comb begin
		sh_nx  = sh_q;
		rem_nx = rem_q;
		for (int k = 0; k < STEPS; k++) begin
			trial = {rem_nx, sh_nx[NB-1]};
			sh_nx = {sh_nx[NB-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				rem_nx   = 4'(trial - {1'b0, d_q});
				sh_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[3:0];
			end
		end
	end

	// sign and saturate the quotient
	always_comb begin
		if (!neg_q) begin
			quo = (sh_q > NB'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : sh_q[31:0];
		end else begin
			quo = (sh_q > NB'(32'h80000000)) ? 32'sh80000000 : 32'(-sh_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == RCW'(ROUNDS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == RCW'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= (mag << 1) + NB'(dmag);
			rem_q <= '0;
			d_q   <= {dmag[2:0], 1'b0};
			neg_q <= num[39] ^ den[4];
		end else if (busy_q) begin
			sh_q  <= sh_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

[hw/rtl/lbe_back.sv]
// Back end: pops a classified request and evaluates each basis function as a
// chain of dual-number products on one shared multiplier. Depends on lbe_pkg, lbe_div.
module lbe_back #(
	parameter int FRAC_BITS      = lbe_pkg::FRAC_BITS_DEF,
	parameter int MAX_LINE_ORDER = lbe_pkg::MAX_LINE_ORDER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         basis_order,
	input  logic               q_valid,
	input  lbe_pkg::item_t     q_item,
	output logic               q_pop,
	output logic               result_valid,
	output logic [3:0]         basis_index,
	output logic signed [31:0] basis_value,
	output logic               last,
	output logic               error
);

	localparam longint OneL = longint'(1) <<< FRAC_BITS;
	localparam logic [31:0] One   = 32'(OneL);
	localparam logic [31:0] Half  = 32'(OneL / 2);
	localparam logic [31:0] Third = 32'((2 * OneL + 3) / 6);
	localparam logic [31:0] Two3  = 32'((4 * OneL + 3) / 6);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_BASIS = 9'b000000010,
		S_TERM  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_M1    = 9'b000010000,
		S_M2    = 9'b000100000,
		S_M3    = 9'b001000000,
		S_M4    = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t             state_q;
	lbe_pkg::item_t     item_q;
	logic [3:0]         cnt_q;
	logic [3:0]         idx_q;
	logic [3:0]         jt_q;
	logic               line_q;
	lbe_pkg::dual_t     acc_q;
	lbe_pkg::dual_t     b_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] pv_q;
	logic signed [31:0] pg_q;
	logic               res_vld_q;
	logic [3:0]         res_idx_q;
	logic [31:0]        res_val_q;
	logic               res_last_q;
	logic               res_err_q;

	lbe_pkg::prog_t     prog;
	lbe_pkg::dual_t     acc_init;
	lbe_pkg::dual_t     b_lin;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] qm;
	logic [3:0]         ki;
	logic [3:0]         kj;
	logic signed [4:0]  den;
	logic signed [39:0] ne;
	logic signed [39:0] num_v;
	logic signed [39:0] num_g;
	logic               div_start;
	logic               div_done;
	logic               div_done_g;
	logic signed [31:0] quo_v;
	logic signed [31:0] quo_g;
	logic               new_err;
	logic [3:0]         new_cnt;
	logic               j_over;

	function automatic logic signed [31:0] scl_apply(input logic signed [31:0] a,
			input lbe_pkg::scl_t s);
		logic signed [63:0] e;
		logic signed [63:0] p;
		e = 64'(a);
		unique case (s)
			lbe_pkg::SCL_2:   p = e <<< 1;
			lbe_pkg::SCL_4:   p = e <<< 2;
			lbe_pkg::SCL_9H:  p = lbe_pkg::rnd_shift((e <<< 3) + e, 1);
			lbe_pkg::SCL_27H: p = lbe_pkg::rnd_shift((e <<< 4) + (e <<< 3) + (e <<< 1) + e, 1);
			lbe_pkg::SCL_27:  p = (e <<< 4) + (e <<< 3) + (e <<< 1) + e;
			default:          p = e;
		endcase
		return lbe_pkg::sat32(p);
	endfunction

	// linear factor: scaled base minus a constant
	function automatic lbe_pkg::dual_t lin_eval(input lbe_pkg::lin_t l,
			input lbe_pkg::item_t it);
		lbe_pkg::dual_t bs;
		lbe_pkg::dual_t r;
		logic [31:0]    c;
		unique case (l.base)
			lbe_pkg::BASE_X: bs = it.x;
			lbe_pkg::BASE_Y: bs = it.y;
			lbe_pkg::BASE_Z: bs = it.z;
			lbe_pkg::BASE_W: bs = it.w;
			lbe_pkg::BASE_U: bs = it.u;
			default: begin
				bs.v = One;
				bs.g = '0;
			end
		endcase
		unique case (l.cst)
			lbe_pkg::CST_HALF:  c = Half;
			lbe_pkg::CST_THIRD: c = Third;
			lbe_pkg::CST_TWO3:  c = Two3;
			default:            c = '0;
		endcase
		r.v = scl_apply($signed(bs.v), l.scl);
		r.g = scl_apply($signed(bs.g), l.scl);
		r.v = lbe_pkg::sat32(64'($signed(r.v)) - 64'($signed(c)));
		return r;
	endfunction

	// line nodes are listed ends first
	function automatic logic [3:0] node_of(input logic [3:0] i, input logic [2:0] n);
		if (i == 4'd0) return 4'd0;
		if (i == 4'd1) return {1'b0, n};
		return i - 4'd1;
	endfunction

	assign result_valid = res_vld_q;
	assign basis_index  = res_idx_q;
	assign basis_value  = res_val_q;
	assign last         = res_last_q;
	assign error        = res_err_q;
	assign q_pop        = (state_q == S_IDLE) && q_valid;

	// result count and support check of the waiting request
	always_comb begin
		new_err = 1'b0;
		new_cnt = 4'd1;
		unique case (q_item.cell_kind)
			lbe_pkg::CELL_LINE: begin
				if (int'(basis_order) > MAX_LINE_ORDER) begin
					new_err = 1'b1;
				end else begin
					new_cnt = {1'b0, basis_order} + 4'd1;
				end
			end
			lbe_pkg::CELL_TRI: begin
				unique case (basis_order)
					3'd0:    new_cnt = 4'd1;
					3'd1:    new_cnt = 4'd3;
					3'd2:    new_cnt = 4'd6;
					3'd3:    new_cnt = 4'd10;
					default: new_err = 1'b1;
				endcase
			end
			lbe_pkg::CELL_TET: begin
				unique case (basis_order)
					3'd0:    new_cnt = 4'd1;
					3'd1:    new_cnt = 4'd4;
					3'd2:    new_cnt = 4'd10;
					default: new_err = 1'b1;
				endcase
			end
			default: new_cnt = 4'd1;
		endcase
	end

	// factor operands
	always_comb begin
		prog     = lbe_pkg::prog_of(item_q.cell_kind, basis_order, idx_q);
		acc_init = lin_eval(prog.l0, item_q);
		b_lin    = lin_eval((jt_q == 4'd1) ? prog.l1 : prog.l2, item_q);
		ki       = node_of(idx_q, basis_order);
		kj       = node_of(jt_q, basis_order);
		den      = $signed({1'b0, ki}) - $signed({1'b0, kj});
		ne       = $signed({37'd0, basis_order});
		num_v    = 40'(ne * 40'($signed(item_q.x.v))) - 40'($signed({36'd0, kj}) * 40'(OneL));
		num_g    = 40'(ne * 40'(OneL));
		j_over   = jt_q > {1'b0, basis_order};
		div_start = (state_q == S_TERM) && line_q && !j_over && (jt_q != idx_q);
	end

	lbe_div u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_v),
		.den    (den),
		.done   (div_done),
		.quo    (quo_v)
	);

	lbe_div u_div_g (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_g),
		.den    (den),
		.done   (div_done_g),
		.quo    (quo_g)
	);

	// shared multiplier: value, then the two product-rule terms
	always_comb begin
		unique case (state_q)
			S_M2: begin
				mul_a = $signed(acc_q.g);
				mul_b = $signed(b_q.v);
			end
			S_M3: begin
				mul_a = $signed(acc_q.v);
				mul_b = $signed(b_q.g);
			end
			default: begin
				mul_a = $signed(acc_q.v);
				mul_b = $signed(b_q.v);
			end
		endcase
		qm = lbe_pkg::sat32(lbe_pkg::rnd_shift(prod_q, FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_M2) pv_q <= qm;
		if (state_q == S_M3) pg_q <= qm;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (new_err) begin
							res_vld_q <= 1'b1;
						end else begin
							state_q <= S_BASIS;
						end
					end
				end
				S_BASIS: state_q <= S_TERM;
				S_TERM: begin
					if (line_q) begin
						if (j_over) begin
							state_q <= S_EMIT;
						end else if (jt_q != idx_q) begin
							state_q <= S_DIV;
						end
					end else if (jt_q > {2'd0, prog.nterm}) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_M1;
					end
				end
				S_DIV: begin
					if (div_done && div_done_g) state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_TERM;
				S_EMIT: begin
					res_vld_q <= 1'b1;
					state_q   <= (idx_q == cnt_q - 4'd1) ? S_IDLE : S_BASIS;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q     <= q_item;
				cnt_q      <= new_cnt;
				idx_q      <= '0;
				line_q     <= (q_item.cell_kind == lbe_pkg::CELL_LINE) && (basis_order != 3'd0);
				res_idx_q  <= '0;
				res_val_q  <= '0;
				res_last_q <= 1'b1;
				res_err_q  <= 1'b1;
			end
			S_BASIS: begin
				if (line_q) begin
					acc_q.v <= One;
					acc_q.g <= '0;
					jt_q    <= '0;
				end else begin
					acc_q <= acc_init;
					jt_q  <= 4'd1;
				end
			end
			S_TERM: begin
				if (line_q) begin
					if (!j_over && jt_q == idx_q) jt_q <= jt_q + 4'd1;
				end else begin
					b_q <= b_lin;
				end
			end
			S_DIV: begin
				b_q.v <= quo_v;
				b_q.g <= quo_g;
			end
			S_M4: begin
				acc_q.v <= pv_q;
				acc_q.g <= lbe_pkg::sat32(64'(pg_q) + 64'(qm));
				jt_q    <= jt_q + 4'd1;
			end
			S_EMIT: begin
				res_idx_q  <= idx_q;
				res_val_q  <= item_q.out_grad ? acc_q.g : acc_q.v;
				res_last_q <= (idx_q == cnt_q - 4'd1);
				res_err_q  <= 1'b0;
				idx_q      <= idx_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/lagrange_basis_eval.sv]
// Top level of the Lagrange basis evaluator: configuration register, front end,
// request queue and back end. Depends on lbe_pkg, lbe_front, lbe_fifo, lbe_back.
//
//   channel   handshake            payload
//   request   start / busy         cell_type, coord_x/y/z, deriv_sel
//   result    result_valid strobe  basis_index, basis_value, last, error
//   config    APB write/read       basis_order at byte address 0
//
// The front end takes a request every cycle while the queue has room; the back
// end forms each simplex basis result from f = 0..2 factor products on the one
// shared multiplier and each line result of order n from n factors, where each
// factor waits on the rounding divider.
// Reset clears control state only; results are strobed once and never held.
module lagrange_basis_eval #(
	parameter int MAX_LINE_ORDER = lbe_pkg::MAX_LINE_ORDER_DEF,
	parameter int FRAC_BITS      = lbe_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cell_type,
	input  logic signed [17:0] coord_x,
	input  logic signed [17:0] coord_y,
	input  logic signed [17:0] coord_z,
	input  logic [1:0]         deriv_sel,
	output logic               result_valid,
	output logic [3:0]         basis_index,
	output logic signed [31:0] basis_value,
	output logic               last,
	output logic               error,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic           [2:0] order_q;
	logic                 push;
	lbe_pkg::item_t       push_item;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;
	lbe_pkg::item_t       q_head;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == lbe_pkg::REG_BASIS_ORDER) ? {29'd0, order_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 3'd1;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == lbe_pkg::REG_BASIS_ORDER) begin
			order_q <= pwdata[2:0];
		end
	end

	lbe_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cell_type (cell_type),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.deriv_sel (deriv_sel),
		.push      (push),
		.push_item (push_item),
		.full      (q_full)
	);

	lbe_fifo #(
		.DEPTH (lbe_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	lbe_back #(
		.FRAC_BITS      (FRAC_BITS),
		.MAX_LINE_ORDER (MAX_LINE_ORDER)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.basis_order  (order_q),
		.q_valid      (q_valid),
		.q_item       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.basis_index  (basis_index),
		.basis_value  (basis_value),
		.last         (last),
		.error        (error)
	);

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of lagrange_basis_eval: per-point basis values and partials
// are predicted in place and compared per result. Depends on lbe_pkg and the RTL.
module tb_top;

	localparam longint ONE = 64'sd65536;
	localparam int N_PHASES = 12;
	localparam int PHASE_ITEMS = 29;

	// value plus the three partials, all Q15.16 held wide
	typedef struct packed {
		longint v;
		longint gx;
		longint gy;
		longint gz;
	} jet_t;

	typedef struct packed {
		logic [1:0]         cell_kind;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic [1:0]         sel;
	} req_t;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [31:0] val;
		logic               last;
		logic               err;
	} basis_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cell_type = '0;
	logic signed [17:0] coord_x = '0;
	logic signed [17:0] coord_y = '0;
	logic signed [17:0] coord_z = '0;
	logic [1:0] deriv_sel = '0;
	logic result_valid;
	logic [3:0] basis_index;
	logic signed [31:0] basis_value;
	logic last;
	logic error;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	req_t       pend_q[$];
	basis_res_t basis_exp_q[$];
	logic [2:0] cur_order = 3'd1;
	int         fails = 0;
	int         gap = 0;
	bit         calm = 1'b0;

	lagrange_basis_eval u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_type(cell_type), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.deriv_sel(deriv_sel), .result_valid(result_valid), .basis_index(basis_index),
		.basis_value(basis_value), .last(last), .error(error),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// fixed-point helpers
	function automatic longint sat(input longint a);
		if (a > 64'sd2147483647) return 64'sd2147483647;
		if (a < -64'sd2147483648) return -64'sd2147483648;
		return a;
	endfunction

	function automatic longint rsh(input longint p, input int s);
		longint m;
		longint r;
		if (s == 0) return p;
		m = p < 0 ? -p : p;
		r = (m + (64'sd1 <<< (s - 1))) >>> s;
		return p < 0 ? -r : r;
	endfunction

	function automatic longint divr(input longint num, input longint den);
		longint m;
		longint d;
		longint q;
		m = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		if (d == 0) return 0;
		q = (2 * m + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return sat(rsh(a * b, 16));
	endfunction

	function automatic jet_t jconst(input longint c);
		jet_t r;
		r = '0;
		r.v = c;
		return r;
	endfunction

	function automatic jet_t jsub(input jet_t a, input jet_t b);
		jet_t r;
		r.v = sat(a.v - b.v);
		r.gx = sat(a.gx - b.gx);
		r.gy = sat(a.gy - b.gy);
		r.gz = sat(a.gz - b.gz);
		return r;
	endfunction

	function automatic jet_t jsubc(input jet_t a, input longint c);
		a.v = sat(a.v - c);
		return a;
	endfunction

	// product rule, each term rounded, then a saturated sum
	function automatic jet_t jmul(input jet_t a, input jet_t b);
		jet_t r;
		r.v = qmul(a.v, b.v);
		r.gx = sat(qmul(a.gx, b.v) + qmul(a.v, b.gx));
		r.gy = sat(qmul(a.gy, b.v) + qmul(a.v, b.gy));
		r.gz = sat(qmul(a.gz, b.v) + qmul(a.v, b.gz));
		return r;
	endfunction

	function automatic jet_t jscale(input jet_t a, input longint num, input int sh);
		a.v = sat(rsh(a.v * num, sh));
		a.gx = sat(rsh(a.gx * num, sh));
		a.gy = sat(rsh(a.gy * num, sh));
		a.gz = sat(rsh(a.gz * num, sh));
		return a;
	endfunction

	function automatic jet_t jcubic(input longint num, input int sh,
			input jet_t a, input jet_t b, input jet_t c);
		return jmul(jmul(jscale(a, num, sh), b), c);
	endfunction

	// line nodes listed ends first
	function automatic longint line_node(input int i, input int n);
		if (i == 0) return 0;
		if (i == 1) return n;
		return i - 1;
	endfunction

	// expected basis results of one accepted request
	task automatic predict_basis(input req_t r, input logic [2:0] order);
		jet_t t[10];
		jet_t one;
		jet_t x;
		jet_t y;
		jet_t z;
		jet_t w;
		jet_t acc;
		jet_t f;
		longint third;
		longint two3;
		longint half;
		longint ki;
		longint kj;
		longint v;
		int n;
		int cnt;
		int sel;
		bit err;
		basis_res_t e;
		n = order;
		cnt = 0;
		err = 1'b0;
		sel = r.sel;
		third = divr(ONE, 3);
		two3 = divr(2 * ONE, 3);
		half = ONE / 2;
		one = jconst(ONE);
		x = jconst(longint'(r.x)); x.gx = ONE;
		y = jconst(longint'(r.y)); y.gy = ONE;
		z = jconst(longint'(r.z)); z.gz = ONE;
		case (lbe_pkg::cell_t'(r.cell_kind))
			lbe_pkg::CELL_POINT: begin
				t[0] = one; sel = 0; cnt = 1;
			end
			lbe_pkg::CELL_LINE: begin
				if (n == 0) begin
					t[0] = one; cnt = 1;
				end else begin
					for (int i = 0; i <= n; i++) begin
						ki = line_node(i, n);
						acc = one;
						for (int j = 0; j <= n; j++) begin
							if (j != i) begin
								kj = line_node(j, n);
								f = jconst(sat(divr(n * x.v - kj * ONE, ki - kj)));
								f.gx = sat(divr(n * ONE, ki - kj));
								acc = jmul(acc, f);
							end
						end
						t[i] = acc;
					end
					cnt = n + 1;
				end
				if (sel != 0) sel = 1;
			end
			lbe_pkg::CELL_TRI: begin
				w = jsub(jsub(one, x), y);
				case (n)
					0: begin t[0] = one; cnt = 1; end
					1: begin t[0] = w; t[1] = x; t[2] = y; cnt = 3; end
					2: begin
						t[0] = jmul(w, jsub(jsub(one, jscale(x, 2, 0)), jscale(y, 2, 0)));
						t[1] = jmul(jscale(x, 2, 0), jsubc(x, half));
						t[2] = jmul(jscale(y, 2, 0), jsubc(y, half));
						t[3] = jmul(jscale(x, 4, 0), w);
						t[4] = jmul(jscale(x, 4, 0), y);
						t[5] = jmul(jscale(y, 4, 0), w);
						cnt = 6;
					end
					3: begin
						t[0] = jcubic(9, 1, w, jsubc(w, two3), jsubc(w, third));
						t[1] = jcubic(9, 1, x, jsubc(x, two3), jsubc(x, third));
						t[2] = jcubic(9, 1, y, jsubc(y, two3), jsubc(y, third));
						t[3] = jcubic(27, 1, w, x, jsubc(w, third));
						t[4] = jcubic(27, 1, w, x, jsubc(x, third));
						t[5] = jcubic(27, 1, x, y, jsubc(x, third));
						t[6] = jcubic(27, 1, x, y, jsubc(y, third));
						t[7] = jcubic(27, 1, y, w, jsubc(y, third));
						t[8] = jcubic(27, 1, y, w, jsubc(w, third));
						t[9] = jcubic(27, 0, w, x, y);
						cnt = 10;
					end
					default: err = 1'b1;
				endcase
			end
			default: begin
				w = jsub(jsub(jsub(one, x), y), z);
				case (n)
					0: begin t[0] = one; cnt = 1; end
					1: begin t[0] = w; t[1] = x; t[2] = y; t[3] = z; cnt = 4; end
					2: begin
						t[0] = jmul(w, jsub(jsub(jsub(one, jscale(x, 2, 0)),
							jscale(y, 2, 0)), jscale(z, 2, 0)));
						t[1] = jmul(jscale(x, 2, 0), jsubc(x, half));
						t[2] = jmul(jscale(y, 2, 0), jsubc(y, half));
						t[3] = jmul(jscale(z, 2, 0), jsubc(z, half));
						t[4] = jmul(jscale(x, 4, 0), w);
						t[5] = jmul(jscale(x, 4, 0), y);
						t[6] = jmul(jscale(y, 4, 0), w);
						t[7] = jmul(jscale(z, 4, 0), w);
						t[8] = jmul(jscale(x, 4, 0), z);
						t[9] = jmul(jscale(y, 4, 0), z);
						cnt = 10;
					end
					default: err = 1'b1;
				endcase
			end
		endcase
		if (err) begin
			e.idx = '0; e.val = '0; e.last = 1'b1; e.err = 1'b1;
			basis_exp_q.push_back(e);
		end else begin
			for (int i = 0; i < cnt; i++) begin
				case (sel)
					0: v = t[i].v;
					1: v = t[i].gx;
					2: v = t[i].gy;
					default: v = t[i].gz;
				endcase
				e.idx = i[3:0];
				e.val = v[31:0];
				e.last = (i == cnt - 1);
				e.err = 1'b0;
				basis_exp_q.push_back(e);
			end
		end
	endtask

	// request driver with random idle bursts
	always @(posedge clk) begin
		req_t r;
		if (arst_n) begin
			if (start && busy) begin
				// hold the request until taken
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (!calm && pend_q.size() != 0 && $urandom_range(0, 7) == 0) begin
				start <= 1'b0;
				gap <= $urandom_range(0, 16);
			end else if (pend_q.size() != 0) begin
				r = pend_q.pop_front();
				start <= 1'b1;
				cell_type <= r.cell_kind;
				coord_x <= r.x;
				coord_y <= r.y;
				coord_z <= r.z;
				deriv_sel <= r.sel;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// accepted request: predict its results
	always @(posedge clk) begin
		req_t r;
		if (arst_n && start && !busy) begin
			r.cell_kind = cell_type; r.x = coord_x; r.y = coord_y; r.z = coord_z;
			r.sel = deriv_sel;
			predict_basis(r, cur_order);
		end
	end

	// result monitor
	always @(posedge clk) begin
		basis_res_t e;
		if (arst_n && result_valid) begin
			if (basis_exp_q.size() == 0) begin
				fails++;
				$display("%0t: unexpected result idx %0d value %0d", $time,
					basis_index, basis_value);
			end else begin
				e = basis_exp_q.pop_front();
				if (basis_index !== e.idx || basis_value !== e.val || last !== e.last ||
						error !== e.err) begin
					fails++;
					$display("%0t: mismatch expected idx %0d val %0d last %0b err %0b",
						$time, e.idx, e.val, e.last, e.err);
					$display("%0t:          actual   idx %0d val %0d last %0b err %0b",
						$time, basis_index, basis_value, last, error);
				end
			end
		end
	end

	task automatic add_req(input lbe_pkg::cell_t c, input int x, input int y, input int z,
			input int sel);
		req_t r;
		r.cell_kind = c; r.x = x[17:0]; r.y = y[17:0]; r.z = z[17:0]; r.sel = sel[1:0];
		pend_q.push_back(r);
	endtask

	// wait until all requests are taken and all results are in, then let it settle
	task automatic wait_idle();
		do @(posedge clk);
		while (pend_q.size() != 0 || start || basis_exp_q.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_order(input logic [2:0] n);
		wait_idle();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {lbe_pkg::REG_BASIS_ORDER, 2'b00}; pwdata <= {29'd0, n};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cur_order <= n;
		@(posedge clk);
	endtask

	function automatic int rand_coord();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: begin
				case ($urandom_range(0, 3))
					0: return -131072;
					1: return 131071;
					2: return 0;
					default: return 65536;
				endcase
			end
			1, 2: return $signed($urandom() & 32'h3FFFF);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic lbe_pkg::cell_t rand_cell(input logic [2:0] n);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return lbe_pkg::CELL_POINT;
		if (n > 3 && k < 8) return lbe_pkg::CELL_LINE;
		if (k < 4) return lbe_pkg::CELL_LINE;
		if (k < 7) return lbe_pkg::CELL_TRI;
		return lbe_pkg::CELL_TET;
	endfunction

	initial begin
		logic [2:0] n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: linear order, ends and extremes, every selector
		write_order(3'd1);
		add_req(lbe_pkg::CELL_POINT, 131071, -131072, 0, 3);
		add_req(lbe_pkg::CELL_LINE, 0, 0, 0, 0);
		add_req(lbe_pkg::CELL_LINE, 65536, 0, 0, 1);
		add_req(lbe_pkg::CELL_LINE, -131072, 131071, 0, 3);
		add_req(lbe_pkg::CELL_TRI, 16384, 16384, 0, 0);
		add_req(lbe_pkg::CELL_TRI, 16384, 16384, 0, 1);
		add_req(lbe_pkg::CELL_TRI, 16384, 16384, 0, 2);
		add_req(lbe_pkg::CELL_TRI, 16384, 16384, 0, 3);
		add_req(lbe_pkg::CELL_TET, 131071, 131071, -131072, 3);
		// order zero: constant one, zero derivatives
		write_order(3'd0);
		add_req(lbe_pkg::CELL_LINE, 30000, 0, 0, 0);
		add_req(lbe_pkg::CELL_TRI, 30000, 1000, 0, 2);
		add_req(lbe_pkg::CELL_TET, 30000, 1000, 5, 3);
		// cubic triangle, tetrahedron beyond its order
		write_order(3'd3);
		add_req(lbe_pkg::CELL_TRI, 131071, -131072, 0, 0);
		add_req(lbe_pkg::CELL_TRI, 21845, 21845, 0, 1);
		add_req(lbe_pkg::CELL_TET, 1000, 1000, 1000, 0);
		add_req(lbe_pkg::CELL_LINE, -131072, 0, 0, 2);
		write_order(3'd2);
		add_req(lbe_pkg::CELL_TET, 10000, 20000, 30000, 0);
		add_req(lbe_pkg::CELL_TET, 10000, 20000, 30000, 3);
		add_req(lbe_pkg::CELL_TRI, -131072, 131071, 0, 2);
		// highest order: line fine, simplices unsupported
		write_order(3'd7);
		add_req(lbe_pkg::CELL_LINE, 131071, 0, 0, 0);
		add_req(lbe_pkg::CELL_LINE, 40000, 0, 0, 2);
		add_req(lbe_pkg::CELL_TRI, 1, 1, 0, 0);
		add_req(lbe_pkg::CELL_TET, 1, 1, 1, 0);

		// random phases over several orders, the last one without idling
		for (int p = 0; p < N_PHASES; p++) begin
			n = (p == 0) ? 3'd7 : (p == 1) ? 3'd0 : 3'($urandom_range(0, 7));
			write_order(n);
			if (p == N_PHASES - 1) calm = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				add_req(rand_cell(n), rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(0, 3));
			end
		end

		wait_idle();
		if (fails == 0) begin
			$display("lagrange_basis_eval verification clean");
		end else begin
			$display("lagrange_basis_eval verification failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#40000000;
		$display("lagrange_basis_eval verification failed");
		$finish;
	end

endmodule
